@@ design/frt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and codes for the free region table.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_RESERVE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REVERSED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] start_address;
        logic [63:0] end_address;
        logic [4:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] free_bytes;
        logic [5:0]  entry_count;
        logic [63:0] read_start;
        logic [63:0] read_length;
    } rsp_t;

endpackage

@@ design/free_region_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_region_table
// Sorted table of free regions with reserve, add and read commands.
//
// channel | dir | fields
// s_axis  | in  | tdata: command, start_address, end_address, entry_index
// m_axis  | out | tdata: status, free_bytes, entry_count, read_start, read_length
//
// Reserve: a read and a write state per table entry scanned, a check for pending
// splits, and a shift insert per split. Add: shift insert, or a direct write into an
// empty table. Read: wait and data states. All others end in the response state.
// One command at a time; input stalls until the response transaction completes.
// Synchronous active-low reset clears count and total; entries are not cleared.
// ----------------------------------------------------------------------------
module free_region_table #(
    parameter int MAX_REGIONS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], start_address[65:2], end_address[129:66], entry_index[134:130]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], free_bytes[65:2], entry_count[71:66], read_start[135:72],
    // read_length[199:136]
    output logic [199:0] m_tdata
);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    frt_pkg::cmd_t cmd;
    frt_pkg::rsp_t rsp;
    logic          mem_we, pend_we;
    logic [AW-1:0] mem_waddr, mem_raddr, pend_waddr, pend_raddr;
    logic [127:0]  mem_wdata, mem_rdata, pend_wdata, pend_rdata;

    assign cmd.command = s_tdata[1:0];
    assign cmd.start_address = s_tdata[65:2];
    assign cmd.end_address = s_tdata[129:66];
    assign cmd.entry_index = s_tdata[134:130];

    assign m_tdata = {rsp.read_length, rsp.read_start,
                      6'(rsp.entry_count), rsp.free_bytes, rsp.status};

    frt_ctrl #(.MAX_REGIONS(MAX_REGIONS), .AW(AW), .CW(CW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(s_tvalid), .cmd_ready(s_tready), .cmd(cmd),
        .rsp_valid(m_tvalid), .rsp_ready(m_tready), .rsp(rsp),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
        .pend_we(pend_we), .pend_waddr(pend_waddr), .pend_wdata(pend_wdata),
        .pend_raddr(pend_raddr), .pend_rdata(pend_rdata)
    );

    frt_mem #(.AW(AW), .DEPTH(MAX_REGIONS)) u_regions (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    frt_mem #(.AW(AW), .DEPTH(MAX_REGIONS)) u_pending (
        .aclk(aclk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
        .raddr(pend_raddr), .rdata(pend_rdata)
    );
endmodule

@@ design/frt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_mem
// Region store: one write port, one registered read port, start and length.
// ----------------------------------------------------------------------------
module frt_mem #(
    parameter int AW = 5,
    parameter int DEPTH = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [127:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [127:0]  rdata
);
    logic [127:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/frt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_ctrl
// Command sequencer: reserve scan, deferred split inserts, shift insert, read.
// ----------------------------------------------------------------------------
module frt_ctrl #(
    parameter int MAX_REGIONS = 32,
    parameter int AW = 5,
    parameter int CW = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  frt_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output frt_pkg::rsp_t   rsp,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output logic [127:0]    mem_wdata,
    output logic [AW-1:0]   mem_raddr,
    input  logic [127:0]    mem_rdata,
    output logic            pend_we,
    output logic [AW-1:0]   pend_waddr,
    output logic [127:0]    pend_wdata,
    output logic [AW-1:0]   pend_raddr,
    input  logic [127:0]    pend_rdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCANR = 4'd1;
    localparam logic [3:0] S_SCANW = 4'd2;
    localparam logic [3:0] S_PREQ  = 4'd3;
    localparam logic [3:0] S_PGET  = 4'd4;
    localparam logic [3:0] S_IREQ  = 4'd5;
    localparam logic [3:0] S_ICMP  = 4'd6;
    localparam logic [3:0] S_RDW   = 4'd7;
    localparam logic [3:0] S_RDD   = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;
    localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [63:0]   total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] npend_reg, npend_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [63:0]   rs_reg, rs_next, re_reg, re_next;
    logic [63:0]   ins_s_reg, ins_s_next, ins_l_reg, ins_l_next;
    logic [1:0]    st_reg, st_next;
    logic          from_pend_reg, from_pend_next;
    logic          rsp_valid_reg, rsp_valid_next;
    frt_pkg::rsp_t rsp_reg, rsp_next;

    logic [63:0] fs, fl;
    logic [64:0] fe;
    logic        carry, hit, sc, ec;

    assign fs = mem_rdata[127:64];
    assign fl = mem_rdata[63:0];
    assign fe = {1'b0, fs} + {1'b0, fl};
    assign carry = fe[64];
    assign hit = (fl != 64'd0) && (fs < re_reg) && (carry || (rs_reg < fe[63:0]));
    assign sc = rs_reg <= fs;
    assign ec = !carry && (re_reg >= fe[63:0]);

    assign cmd_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_comb begin
        state_next = state_reg;
        used_next = used_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        npend_next = npend_reg;
        pidx_next = pidx_reg;
        rs_next = rs_reg;
        re_next = re_reg;
        ins_s_next = ins_s_reg;
        ins_l_next = ins_l_reg;
        st_next = st_reg;
        from_pend_next = from_pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = {ins_s_reg, ins_l_reg};
        mem_raddr = idx_reg[AW-1:0];
        pend_we = 1'b0;
        pend_waddr = npend_reg[AW-1:0];
        pend_wdata = {re_reg, 64'd0};
        pend_raddr = pidx_reg[AW-1:0];
        if (rsp_valid_reg && rsp_ready) begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    rs_next = cmd.start_address;
                    re_next = cmd.end_address;
                    st_next = frt_pkg::ST_OK;
                    idx_next = '0;
                    npend_next = '0;
                    pidx_next = '0;
                    ins_s_next = cmd.start_address;
                    ins_l_next = cmd.end_address - cmd.start_address;
                    from_pend_next = 1'b0;
                    state_next = S_RESP;
                    case (cmd.command)
                        frt_pkg::CMD_ADD: begin
                            if (cmd.end_address < cmd.start_address) begin
                                st_next = frt_pkg::ST_REVERSED;
                            end else if (used_reg >= MAXC) begin
                                st_next = frt_pkg::ST_FULL;
                            end else begin
                                idx_next = used_reg;
                                used_next = used_reg + 1'b1;
                                state_next = S_IREQ;
                            end
                        end
                        frt_pkg::CMD_RESERVE: begin
                            if (cmd.end_address < cmd.start_address) begin
                                st_next = frt_pkg::ST_REVERSED;
                            end else if (cmd.end_address != cmd.start_address
                                         && used_reg != '0) begin
                                state_next = S_SCANR;
                            end
                        end
                        frt_pkg::CMD_READ: begin
                            if (CW'(cmd.entry_index) >= used_reg) begin
                                st_next = frt_pkg::ST_RANGE;
                            end else begin
                                idx_next = CW'(cmd.entry_index);
                                state_next = S_RDW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCANR: begin
                state_next = S_SCANW;
            end
            S_SCANW: begin
                if (hit) begin
                    mem_we = 1'b1;
                    if (sc && ec) begin
                        total_next = total_reg - fl;
                        mem_wdata = {fs, 64'd0};
                    end else if (sc) begin
                        total_next = total_reg - (re_reg - fs);
                        mem_wdata = {re_reg, fl - (re_reg - fs)};
                    end else begin
                        total_next = total_reg - (fl - (rs_reg - fs));
                        mem_wdata = {fs, rs_reg - fs};
                        if (!ec) begin
                            pend_we = 1'b1;
                            pend_wdata = {re_reg, fl - (re_reg - fs)};
                            npend_next = npend_reg + 1'b1;
                        end
                    end
                end
                if (idx_reg + 1'b1 >= used_reg) begin
                    state_next = S_PREQ;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCANR;
                end
            end
            S_PREQ: begin
                if (pidx_reg >= npend_reg) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_PGET;
                end
            end
            S_PGET: begin
                pidx_next = pidx_reg + 1'b1;
                ins_s_next = pend_rdata[127:64];
                ins_l_next = pend_rdata[63:0];
                if (used_reg >= MAXC) begin
                    st_next = frt_pkg::ST_FULL;
                    state_next = S_PREQ;
                end else begin
                    from_pend_next = 1'b1;
                    idx_next = used_reg;
                    used_next = used_reg + 1'b1;
                    state_next = S_IREQ;
                end
            end
            S_IREQ: begin
                mem_raddr = idx_reg[AW-1:0] - 1'b1;
                if (idx_reg == '0) begin
                    mem_we = 1'b1;
                    total_next = total_reg + ins_l_reg;
                    state_next = from_pend_reg ? S_PREQ : S_RESP;
                end else begin
                    state_next = S_ICMP;
                end
            end
            S_ICMP: begin
                if (ins_s_reg > fs) begin
                    mem_we = 1'b1;
                    mem_wdata = mem_rdata;
                    idx_next = idx_reg - 1'b1;
                    state_next = S_IREQ;
                end else begin
                    mem_we = 1'b1;
                    total_next = total_reg + ins_l_reg;
                    state_next = from_pend_reg ? S_PREQ : S_RESP;
                end
            end
            S_RDW: begin
                state_next = S_RDD;
            end
            S_RDD: begin
                ins_s_next = fs;
                ins_l_next = fl;
                state_next = S_RESP;
            end
            S_RESP: begin
                rsp_valid_next = 1'b1;
                rsp_next.status = st_reg;
                rsp_next.free_bytes = total_reg;
                rsp_next.entry_count = 6'(used_reg);
                rsp_next.read_start = '0;
                rsp_next.read_length = '0;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_RDD) begin
            rsp_next.read_start = fs;
            rsp_next.read_length = fl;
            rsp_next.status = frt_pkg::ST_OK;
            rsp_next.free_bytes = total_reg;
            rsp_next.entry_count = 6'(used_reg);
            rsp_valid_next = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            total_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            total_reg <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        npend_reg <= npend_next;
        pidx_reg <= pidx_next;
        rs_reg <= rs_next;
        re_reg <= re_next;
        ins_s_reg <= ins_s_next;
        ins_l_reg <= ins_l_next;
        st_reg <= st_next;
        from_pend_reg <= from_pend_next;
        rsp_reg <= rsp_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) used_reg <= MAXC)
        else $error("entry count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd_ready)
        else $error("ready while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg)
        else $error("response dropped");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free region table. A directed table covers
// reset, extremes, errors, clips, splits and a full table; random add,
// reserve and read traffic follows. Every response is compared with an
// in-bench model of the sorted region table.
// ----------------------------------------------------------------------------
module tb;

    localparam int NREG = 32;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1800;
    localparam int HOLD_CYCLES = 600;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;

    free_region_table #(.MAX_REGIONS(NREG)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic        fixed;
        logic [1:0]  command;
        logic [63:0] start_address;
        logic [63:0] end_address;
        logic [4:0]  entry_index;
        logic [1:0]  status;
        logic [63:0] free_bytes;
        logic [5:0]  entry_count;
    } row_t;

    logic [63:0] tbl_start [NREG];
    logic [63:0] tbl_len   [NREG];
    int unsigned tbl_used;
    logic [63:0] tbl_free;

    frt_pkg::rsp_t rsp_queue[$];
    row_t fixed_queue[$];
    int   mismatches;
    bit   quiet;
    bit   hold_rx;
    int   idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit table_insert(logic [63:0] s, logic [63:0] len);
        int unsigned i;
        if (tbl_used >= NREG) return 1'b0;
        i = tbl_used;
        tbl_used++;
        while (i > 0 && s > tbl_start[i-1]) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_len[i]   = tbl_len[i-1];
            i--;
        end
        tbl_start[i] = s;
        tbl_len[i]   = len;
        tbl_free     = tbl_free + len;
        return 1'b1;
    endfunction

    function automatic logic [1:0] table_reserve(logic [63:0] rs, logic [63:0] re);
        logic [63:0] ps [NREG];
        logic [63:0] pl [NREG];
        int unsigned np;
        logic [1:0]  st;
        logic [64:0] fe;
        logic [63:0] fs, len;
        bit          carry, sc, ec;
        np = 0;
        st = frt_pkg::ST_OK;
        if (re == rs) return frt_pkg::ST_OK;
        for (int unsigned i = 0; i < tbl_used; i++) begin
            fs = tbl_start[i];
            len = tbl_len[i];
            fe = {1'b0, fs} + {1'b0, len};
            carry = fe[64];
            if (len == 0) continue;
            if (!(fs < re && (carry || rs < fe[63:0]))) continue;
            sc = rs <= fs;
            ec = !carry && re >= fe[63:0];
            if (sc && ec) begin
                tbl_free = tbl_free - len;
                tbl_len[i] = '0;
            end else if (sc) begin
                tbl_start[i] = re;
                tbl_len[i] = len - (re - fs);
                tbl_free = tbl_free - (re - fs);
            end else if (ec) begin
                tbl_len[i] = rs - fs;
                tbl_free = tbl_free - (len - (rs - fs));
            end else begin
                tbl_len[i] = rs - fs;
                tbl_free = tbl_free - (len - (rs - fs));
                if (np < NREG) begin
                    ps[np] = re;
                    pl[np] = len - (re - fs);
                    np++;
                end
            end
        end
        for (int unsigned i = 0; i < np; i++)
            if (!table_insert(ps[i], pl[i])) st = frt_pkg::ST_FULL;
        return st;
    endfunction

    function automatic frt_pkg::rsp_t predict_response(frt_pkg::cmd_t c);
        frt_pkg::rsp_t r;
        r = '0;
        case (c.command)
            frt_pkg::CMD_ADD: begin
                if (c.end_address < c.start_address) r.status = frt_pkg::ST_REVERSED;
                else if (!table_insert(c.start_address, c.end_address - c.start_address))
                    r.status = frt_pkg::ST_FULL;
            end
            frt_pkg::CMD_RESERVE: begin
                if (c.end_address < c.start_address) r.status = frt_pkg::ST_REVERSED;
                else r.status = table_reserve(c.start_address, c.end_address);
            end
            frt_pkg::CMD_READ: begin
                if (c.entry_index >= tbl_used) r.status = frt_pkg::ST_RANGE;
                else begin
                    r.read_start  = tbl_start[c.entry_index];
                    r.read_length = tbl_len[c.entry_index];
                end
            end
            default: ;
        endcase
        r.free_bytes  = tbl_free;
        r.entry_count = tbl_used[5:0];
        return r;
    endfunction

    function automatic logic [135:0] pack_cmd(frt_pkg::cmd_t c);
        return {1'b0, c.entry_index, c.end_address, c.start_address, c.command};
    endfunction

    task automatic send_cmd(frt_pkg::cmd_t c, row_t fx);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cmd(c);
        do @(posedge aclk); while (!s_tready);
        rsp_queue.push_back(predict_response(c));
        fixed_queue.push_back(fx);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] near_region(logic [63:0] base);
        case ($urandom_range(0, 3))
            0: return rand64();
            1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
            default: return base + 64'($urandom_range(0, 300));
        endcase
    endfunction

    // directed rows: fixed=1 checks status, total and count as typed
    row_t dir_rows[] = '{
        '{1, frt_pkg::CMD_READ,    64'd0, 64'd0, 5'd0,  frt_pkg::ST_RANGE, 64'd0, 6'd0},
        '{1, frt_pkg::CMD_RESERVE, 64'd5, 64'd9, 5'd0,  frt_pkg::ST_OK,    64'd0, 6'd0},
        '{1, frt_pkg::CMD_ADD,     64'd9, 64'd5, 5'd0,  frt_pkg::ST_REVERSED, 64'd0, 6'd0},
        '{1, frt_pkg::CMD_ADD,     64'd100, 64'd200, 5'd0, frt_pkg::ST_OK, 64'd100, 6'd1},
        '{1, frt_pkg::CMD_ADD,     64'd1000, 64'd1000, 5'd0, frt_pkg::ST_OK,
          64'd100, 6'd2},
        '{1, CMD_NONE,             64'd1, 64'd2, 5'd31, frt_pkg::ST_OK, 64'd100, 6'd2},
        '{1, frt_pkg::CMD_ADD,     64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0,
          frt_pkg::ST_OK, 64'd355, 6'd3},
        '{0, frt_pkg::CMD_READ,    64'd0, 64'd0, 5'd0,  frt_pkg::ST_OK, 64'd0, 6'd0},
        '{0, frt_pkg::CMD_READ,    64'd0, 64'd0, 5'd2,  frt_pkg::ST_OK, 64'd0, 6'd0},
        '{1, frt_pkg::CMD_READ,    64'd0, 64'd0, 5'd31, frt_pkg::ST_RANGE, 64'd355, 6'd3},
        '{1, frt_pkg::CMD_RESERVE, 64'd150, 64'd160, 5'd0, frt_pkg::ST_OK, 64'd345, 6'd4},
        '{1, frt_pkg::CMD_RESERVE, 64'd50, 64'd120, 5'd0, frt_pkg::ST_OK, 64'd325, 6'd4},
        '{1, frt_pkg::CMD_RESERVE, 64'd190, 64'd300, 5'd0, frt_pkg::ST_OK, 64'd315, 6'd4},
        '{1, frt_pkg::CMD_RESERVE, 64'd160, 64'd160, 5'd0, frt_pkg::ST_OK, 64'd315, 6'd4},
        '{1, frt_pkg::CMD_RESERVE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, frt_pkg::ST_OK,
          64'd0, 6'd4},
        '{0, frt_pkg::CMD_READ,    64'd0, 64'd0, 5'd3,  frt_pkg::ST_OK, 64'd0, 6'd0},
        '{1, frt_pkg::CMD_RESERVE, 64'd7, 64'd3, 5'd0,  frt_pkg::ST_REVERSED, 64'd0, 6'd4},
        '{0, frt_pkg::CMD_ADD,     64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, frt_pkg::ST_OK,
          64'd0, 6'd0},
        '{0, frt_pkg::CMD_ADD,     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0,
          frt_pkg::ST_OK, 64'd0, 6'd0}
    };

    initial begin
        frt_pkg::cmd_t c;
        row_t fx;
        logic [63:0] a, b;
        int unsigned k;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        tbl_used = 0;
        tbl_free = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            c = '{dir_rows[i].command, dir_rows[i].start_address,
                  dir_rows[i].end_address, dir_rows[i].entry_index};
            send_cmd(c, dir_rows[i]);
        end
        // fill the table, then force a split with no room
        fx = '0;
        for (k = 0; k < NREG + 2; k++) begin
            c = '{frt_pkg::CMD_ADD, 64'd10000 + 64'(k) * 100,
                  64'd10000 + 64'(k) * 100 + 50, 5'd0};
            send_cmd(c, fx);
        end
        send_cmd('{frt_pkg::CMD_RESERVE, 64'd10010, 64'd10020, 5'd0}, fx);
        send_cmd('{frt_pkg::CMD_READ, 64'd0, 64'd0, 5'd31}, fx);
        drain();
        // pressure: stall the receiver while commands keep coming
        hold_rx = 1'b1;

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) quiet = 1'b1;
            k = $urandom_range(0, 99);
            a = (tbl_used > 0) ? tbl_start[$urandom_range(0, tbl_used - 1)] : rand64();
            c.entry_index = 5'($urandom);
            c.start_address = near_region(a);
            c.end_address = c.start_address + 64'($urandom_range(0, 400));
            if ($urandom_range(0, 19) == 0) c.end_address = rand64();
            if (k < 30) c.command = frt_pkg::CMD_ADD;
            else if (k < 65) c.command = frt_pkg::CMD_RESERVE;
            else if (k < 97) c.command = frt_pkg::CMD_READ;
            else c.command = CMD_NONE;
            if (c.command == frt_pkg::CMD_ADD && tbl_used >= NREG - 2
                && $urandom_range(0, 3) != 0)
                c.command = frt_pkg::CMD_RESERVE;
            // now and then reserve from zero up to empty most regions; entries stay in the table
            if (c.command == frt_pkg::CMD_RESERVE && $urandom_range(0, 40) == 0) begin
                b = rand64();
                c.start_address = 64'd0;
                c.end_address = b | 64'hFFFF_0000_0000_0000;
            end
            send_cmd(c, fx);
        end
        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && fixed_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // drive the receiver: one long hold on request, random gaps otherwise
    initial begin
        int hold;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_rx && !held) begin
                m_tready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold++;
                end
                held = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        frt_pkg::rsp_t got, want;
        row_t fx;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[65:2], m_tdata[71:66], m_tdata[135:72],
                   m_tdata[199:136]};
            if (rsp_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", m_tdata);
            end else begin
                want = rsp_queue.pop_front();
                fx = fixed_queue.pop_front();
                if (fx.fixed) begin
                    want.status = fx.status;
                    want.free_bytes = fx.free_bytes;
                    want.entry_count = fx.entry_count;
                end
                if (got.status != want.status || got.free_bytes != want.free_bytes ||
                    got.entry_count != want.entry_count ||
                    got.read_start != want.read_start ||
                    got.read_length != want.read_length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d free=%h cnt=%0d rs=%h rl=%h",
                                  " | got st=%0d free=%h cnt=%0d rs=%h rl=%h"},
                                 want.status, want.free_bytes, want.entry_count,
                                 want.read_start, want.read_length, got.status,
                                 got.free_bytes, got.entry_count, got.read_start,
                                 got.read_length);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
